### design/imuc_pkg.sv
// imuc_pkg: shared types, codes and calibration constants of the imu axis calibration block
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package imuc_pkg;

  // sensor select codes
  localparam logic [1:0] FUNC_ACCEL = 2'd0;
  localparam logic [1:0] FUNC_MAG   = 2'd1;
  localparam logic [1:0] FUNC_GYRO  = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_ACCEL_SCALE = 2'd0;
  localparam logic [1:0] REG_MAG_SCALE   = 2'd1;
  localparam logic [1:0] REG_GYRO_SCALE  = 2'd2;

  localparam logic [31:0] ACCEL_SCALE_RST = 32'd2569298;
  localparam logic [31:0] MAG_SCALE_RST   = 32'd601295;
  localparam logic [31:0] GYRO_SCALE_RST  = 32'd655930;

  localparam int DIFF_W = 19;  // raw * 4 minus bias
  localparam int ACC_W  = 35;  // q.16 sums, magnitude below 2^34
  localparam int MAG_W  = 34;

  typedef logic signed [15:0] coef_t;

  // bias vectors in q.2, gyro offsets in raw counts, matrices in q2.14
  localparam coef_t ACC_BIAS [3] = '{-16'sd837, -16'sd1724, -16'sd328};
  localparam coef_t MAG_BIAS [3] = '{-16'sd1475, 16'sd9937, 16'sd3488};
  localparam coef_t GYR_OFF  [3] = '{16'sd65, -16'sd13, 16'sd21};

  localparam coef_t ACC_MAT [3][3] = '{
    '{16'sd16338, -16'sd20,    16'sd34},
    '{-16'sd20,   16'sd16471, -16'sd50},
    '{16'sd34,   -16'sd50,     16'sd16304}};

  localparam coef_t MAG_MAT [3][3] = '{
    '{16'sd22107, 16'sd996,   16'sd241},
    '{16'sd996,   16'sd21423, 16'sd151},
    '{16'sd241,   16'sd151,   16'sd22111}};

  // corrected sample in q.16 between the matrix and the scaling sections
  typedef struct packed {
    logic                    vld;
    logic [1:0]              func;
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic signed [ACC_W-1:0] acc_z;
  } imuc_acc_t;

  typedef struct packed {
    logic [31:0] accel;
    logic [31:0] mag;
    logic [31:0] gyro;
  } imuc_scale_t;

endpackage

### design/imuc_cfg_regs.sv
// imuc_cfg_regs: the three unit scale registers of the calibration block
// depends on imuc_pkg
`timescale 1ns / 1ps

module imuc_cfg_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_wdata,
  output imuc_pkg::imuc_scale_t scale_o
);

  logic [31:0] accel_r;
  logic [31:0] mag_r;
  logic [31:0] gyro_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= imuc_pkg::ACCEL_SCALE_RST;
      mag_r   <= imuc_pkg::MAG_SCALE_RST;
      gyro_r  <= imuc_pkg::GYRO_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        imuc_pkg::REG_ACCEL_SCALE: accel_r <= cfg_wdata;
        imuc_pkg::REG_MAG_SCALE:   mag_r   <= cfg_wdata;
        imuc_pkg::REG_GYRO_SCALE:  gyro_r  <= cfg_wdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign scale_o.accel = accel_r;
  assign scale_o.mag   = mag_r;
  assign scale_o.gyro  = gyro_r;

endmodule

### design/imuc_bias_matrix.sv
// imuc_bias_matrix: bias subtraction and 3x3 correction, three register stages
// depends on imuc_pkg; feeds imuc_scale_sat with q.16 corrected axes
`timescale 1ns / 1ps

module imuc_bias_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [1:0]          in_func,
  input  logic signed [15:0]  in_raw_x,
  input  logic signed [15:0]  in_raw_y,
  input  logic signed [15:0]  in_raw_z,
  output imuc_pkg::imuc_acc_t acc_o
);

  localparam int DW = imuc_pkg::DIFF_W;
  localparam int AW = imuc_pkg::ACC_W;

  logic signed [15:0] raw [3];
  logic signed [DW-1:0] d_nxt [3];
  logic signed [AW-1:0] p_nxt [3][3];
  logic signed [AW-1:0] acc_nxt [3];

  logic                 vld1_r;
  logic [1:0]           func1_r;
  logic signed [DW-1:0] d1_r [3];

  logic                 vld2_r;
  logic [1:0]           func2_r;
  logic signed [AW-1:0] p2_r [3][3];

  logic                 vld3_r;
  logic [1:0]           func3_r;
  logic signed [AW-1:0] acc3_r [3];

  assign raw[0] = in_raw_x;
  assign raw[1] = in_raw_y;
  assign raw[2] = in_raw_z;

  // stage 1: q.2 difference, or plain offset removal for the gyro
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (in_func == imuc_pkg::FUNC_GYRO) begin
        d_nxt[i] = DW'(raw[i]) - DW'(imuc_pkg::GYR_OFF[i]);
      end else if (in_func == imuc_pkg::FUNC_ACCEL) begin
        d_nxt[i] = {raw[i][15], raw[i], 2'b00} - DW'(imuc_pkg::ACC_BIAS[i]);
      end else begin
        d_nxt[i] = {raw[i][15], raw[i], 2'b00} - DW'(imuc_pkg::MAG_BIAS[i]);
      end
    end
  end

  // stage 2: nine products; gyro goes straight to q.16 on the diagonal, unused select gives zeros
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (func1_r == imuc_pkg::FUNC_GYRO) begin
          p_nxt[i][j] = (i == j) ? {d1_r[j], 16'b0} : '0;
        end else if (func1_r == imuc_pkg::FUNC_NONE) begin
          p_nxt[i][j] = '0;
        end else if (func1_r == imuc_pkg::FUNC_ACCEL) begin
          p_nxt[i][j] = AW'(imuc_pkg::ACC_MAT[i][j]) * AW'(d1_r[j]);
        end else begin
          p_nxt[i][j] = AW'(imuc_pkg::MAG_MAT[i][j]) * AW'(d1_r[j]);
        end
      end
    end
  end

  // stage 3: row sums
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_nxt[i] = p2_r[i][0] + p2_r[i][1] + p2_r[i][2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    func1_r <= in_func;
    d1_r    <= d_nxt;
    func2_r <= func1_r;
    p2_r    <= p_nxt;
    func3_r <= func2_r;
    acc3_r  <= acc_nxt;
  end

  assign acc_o = {vld3_r, func3_r, acc3_r[0], acc3_r[1], acc3_r[2]};

`ifndef NO_ASSERTIONS
  a_vld_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |-> ##3 acc_o.vld)
    else $error("request lost in matrix stages");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    acc_o.vld && acc_o.func == imuc_pkg::FUNC_NONE
      |-> acc_o.acc_x == '0 && acc_o.acc_y == '0 && acc_o.acc_z == '0)
    else $error("unused select gave a nonzero sum");

  a_gyro_frac: assert property (@(posedge clk) disable iff (!rst_n)
    acc_o.vld && acc_o.func == imuc_pkg::FUNC_GYRO
      |-> acc_o.acc_x[15:0] == '0 && acc_o.acc_y[15:0] == '0 && acc_o.acc_z[15:0] == '0)
    else $error("gyro sum has fraction bits");
`endif

endmodule

### design/imuc_scale_sat.sv
// imuc_scale_sat: unit scaling, rounding and saturation to q16.16, four register stages
// depends on imuc_pkg; takes q.16 axes from imuc_bias_matrix
`timescale 1ns / 1ps

module imuc_scale_sat (
  input  logic                  clk,
  input  logic                  rst_n,
  input  imuc_pkg::imuc_acc_t   acc_i,
  input  imuc_pkg::imuc_scale_t scale_i,
  output logic                  out_valid,
  output logic [1:0]            out_sensor_tag,
  output logic signed [31:0]    out_cal_x,
  output logic signed [31:0]    out_cal_y,
  output logic signed [31:0]    out_cal_z
);

  localparam int AW = imuc_pkg::ACC_W;
  localparam int MW = imuc_pkg::MAG_W;
  localparam int PW = MW + 16;
  localparam int UW = PW + 1;
  localparam int RW = UW - 16;

  logic signed [AW-1:0] a [3];
  logic signed [AW-1:0] a_neg [3];
  logic [31:0]          scale_sel;
  logic [UW-1:0]        t_sum [3];
  logic [UW-1:0]        u_sum [3];
  logic [RW-1:0]        r_neg [3];
  logic [31:0]          cal_nxt [3];

  logic          vld4_r, vld5_r, vld6_r, vld7_r;
  logic [1:0]    func4_r, func5_r, func6_r, func7_r;
  logic [2:0]    neg4_r, neg5_r, neg6_r;
  logic [MW-1:0] mag4_r [3];
  logic [15:0]   sh4_r;
  logic [15:0]   sl4_r;
  logic [PW-1:0] plo5_r [3];
  logic [PW-1:0] phi5_r [3];
  logic [RW-1:0] r6_r [3];
  logic [31:0]   cal7_r [3];

  assign a[0] = acc_i.acc_x;
  assign a[1] = acc_i.acc_y;
  assign a[2] = acc_i.acc_z;

  always_comb begin
    case (acc_i.func)
      imuc_pkg::FUNC_ACCEL: scale_sel = scale_i.accel;
      imuc_pkg::FUNC_MAG:   scale_sel = scale_i.mag;
      default:              scale_sel = scale_i.gyro;
    endcase
  end

  // round half away from zero on the magnitude: (m * scale + 2^31) >> 32
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_neg[i]   = -a[i];
      t_sum[i]   = {1'b0, plo5_r[i]} + UW'(32'h8000_0000);
      u_sum[i]   = {1'b0, phi5_r[i]} + UW'(t_sum[i][UW-1:16]);
      r_neg[i]   = -r6_r[i];
      if (neg6_r[i]) begin
        cal_nxt[i] = (r6_r[i] > RW'(32'h8000_0000)) ? 32'h8000_0000 : r_neg[i][31:0];
      end else begin
        cal_nxt[i] = (r6_r[i] > RW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r6_r[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else begin
      vld4_r <= acc_i.vld;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
    end
  end

  always_ff @(posedge clk) begin
    func4_r <= acc_i.func;
    sh4_r   <= scale_sel[31:16];
    sl4_r   <= scale_sel[15:0];
    func5_r <= func4_r;
    neg5_r  <= neg4_r;
    func6_r <= func5_r;
    neg6_r  <= neg5_r;
    func7_r <= func6_r;
    for (int i = 0; i < 3; i++) begin
      neg4_r[i] <= a[i][AW-1];
      mag4_r[i] <= a[i][AW-1] ? a_neg[i][MW-1:0] : a[i][MW-1:0];
      plo5_r[i] <= PW'(mag4_r[i]) * PW'(sl4_r);
      phi5_r[i] <= PW'(mag4_r[i]) * PW'(sh4_r);
      r6_r[i]   <= u_sum[i][UW-1:16];
      cal7_r[i] <= cal_nxt[i];
    end
  end

  assign out_valid      = vld7_r;
  assign out_sensor_tag = func7_r;
  assign out_cal_x      = cal7_r[0];
  assign out_cal_y      = cal7_r[1];
  assign out_cal_z      = cal7_r[2];

`ifndef NO_ASSERTIONS
  a_vld_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc_i.vld |-> ##4 out_valid)
    else $error("request lost in scaling stages");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sensor_tag == imuc_pkg::FUNC_NONE
      |-> out_cal_x == '0 && out_cal_y == '0 && out_cal_z == '0)
    else $error("unused select gave a nonzero result");

  a_sign_kept: assert property (@(posedge clk) disable iff (!rst_n)
    acc_i.vld && !acc_i.acc_x[AW-1] |-> ##4 !out_cal_x[31])
    else $error("positive x axis came out negative");
`endif

endmodule

### design/imu_axis_calibration_unit.sv
// Three-axis IMU calibration: accelerometer and magnetometer samples get bias removal and a
// fixed 3x3 correction, gyro samples get offset removal; every axis is then scaled by the
// sensor's Q0.32 unit register and returned as saturated signed Q16.16. A request is taken
// on any cycle with start high (busy stays low), one per clock, and its result shows on the
// out_ ports with out_valid for one cycle, after 3 stages for bias and matrix and 4 for the
// split 34x16 scale multiplies, rounding and saturation. Results leave in request order and
// cannot be held off. Scale registers must be written by the user through cfg_we only
// while no request is in flight; the block does not enforce this. An index of 3 is ignored.
// depends on imuc_pkg, imuc_cfg_regs, imuc_bias_matrix, imuc_scale_sat
`timescale 1ns / 1ps

module imu_axis_calibration_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_raw_x,
  input  logic signed [15:0] in_raw_y,
  input  logic signed [15:0] in_raw_z,
  output logic               out_valid,
  output logic [1:0]         out_sensor_tag,
  output logic signed [31:0] out_cal_x,
  output logic signed [31:0] out_cal_y,
  output logic signed [31:0] out_cal_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  imuc_pkg::imuc_scale_t scale;
  imuc_pkg::imuc_acc_t   acc;
  logic                  in_vld;

  // fully pipelined, never stalls
  assign busy   = 1'b0;
  assign in_vld = start && !busy;

  imuc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .scale_o   (scale)
  );

  imuc_bias_matrix u_mat (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .in_func  (in_func),
    .in_raw_x (in_raw_x),
    .in_raw_y (in_raw_y),
    .in_raw_z (in_raw_z),
    .acc_o    (acc)
  );

  imuc_scale_sat u_scl (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc_i          (acc),
    .scale_i        (scale),
    .out_valid      (out_valid),
    .out_sensor_tag (out_sensor_tag),
    .out_cal_x      (out_cal_x),
    .out_cal_y      (out_cal_y),
    .out_cal_z      (out_cal_z)
  );

endmodule

### tb/tb_imu_axis_calibration_unit.sv
// tb_imu_axis_calibration_unit: self-checking testbench of the imu axis calibration unit,
// bit-exact predictor in a scoreboard class, directed extremes then random requests
// depends on imuc_pkg and imu_axis_calibration_unit
`timescale 1ns / 1ps

module tb_imu_axis_calibration_unit;

  localparam int GAP_MAX         = 9;
  localparam int IDLE_LIMIT      = 500;
  localparam int DRAIN_CYCLES    = 20;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 142;

  localparam logic [1:0]  REG_UNUSED = 2'd3;
  localparam logic [31:0] SCALE_MAX  = 32'hFFFF_FFFF;

  localparam logic [31:0] ACCEL_SCALE_RESET = 32'd2569298;
  localparam logic [31:0] MAG_SCALE_RESET   = 32'd601295;
  localparam logic [31:0] GYRO_SCALE_RESET  = 32'd655930;

  localparam longint ACCEL_BIAS [3]  = '{-837, -1724, -328};
  localparam longint MAG_BIAS [3]    = '{-1475, 9937, 3488};
  localparam longint GYRO_OFFSET [3] = '{65, -13, 21};
  localparam longint ACCEL_MATRIX [3][3] = '{
    '{16338, -20, 34}, '{-20, 16471, -50}, '{34, -50, 16304}};
  localparam longint MAG_MATRIX [3][3] = '{
    '{22107, 996, 241}, '{996, 21423, 151}, '{241, 151, 22111}};

  typedef struct {
    logic [1:0]         tag;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cal_result_t;

  class cal_scoreboard;
    cal_result_t pending_cal[$];
    logic [31:0] accel_scale;
    logic [31:0] mag_scale;
    logic [31:0] gyro_scale;
    int          errors;

    function new();
      accel_scale = ACCEL_SCALE_RESET;
      mag_scale   = MAG_SCALE_RESET;
      gyro_scale  = GYRO_SCALE_RESET;
      errors      = 0;
    endfunction

    function void set_scale(logic [1:0] idx, logic [31:0] val);
      case (idx)
        imuc_pkg::REG_ACCEL_SCALE: accel_scale = val;
        imuc_pkg::REG_MAG_SCALE:   mag_scale = val;
        imuc_pkg::REG_GYRO_SCALE:  gyro_scale = val;
        default: ;
      endcase
    endfunction

    // q.16 times q0.32, magnitude rounded half away from zero, saturated to q16.16
    function logic [31:0] round_sat_q16(longint acc, logic [31:0] s);
      logic        neg;
      logic [63:0] m;
      logic [63:0] t;
      logic [63:0] u;
      logic [63:0] r;
      neg = acc < 0;
      m = neg ? -acc : acc;
      t = m * s[15:0] + 64'h8000_0000;
      u = m * s[31:16] + (t >> 16);
      r = u >> 16;
      if (neg) begin
        if (r > 64'h8000_0000) r = 64'h8000_0000;
        r = -r;
      end else begin
        if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
      end
      return r[31:0];
    endfunction

    function cal_result_t predict_cal(logic [1:0] f, logic signed [15:0] rx,
                                      logic signed [15:0] ry, logic signed [15:0] rz);
      cal_result_t res;
      longint      raw [3];
      longint      diff [3];
      longint      acc [3];
      logic [31:0] s;
      res.tag = f;
      raw[0] = rx;
      raw[1] = ry;
      raw[2] = rz;
      if (f == imuc_pkg::FUNC_NONE) begin
        res.x = 0;
        res.y = 0;
        res.z = 0;
        return res;
      end
      if (f == imuc_pkg::FUNC_GYRO) begin
        for (int i = 0; i < 3; i++) acc[i] = (raw[i] - GYRO_OFFSET[i]) * 65536;
        s = gyro_scale;
      end else begin
        for (int i = 0; i < 3; i++)
          diff[i] = raw[i] * 4 -
                    ((f == imuc_pkg::FUNC_ACCEL) ? ACCEL_BIAS[i] : MAG_BIAS[i]);
        for (int i = 0; i < 3; i++) begin
          acc[i] = 0;
          for (int j = 0; j < 3; j++)
            acc[i] += ((f == imuc_pkg::FUNC_ACCEL) ? ACCEL_MATRIX[i][j] : MAG_MATRIX[i][j])
                      * diff[j];
        end
        s = (f == imuc_pkg::FUNC_ACCEL) ? accel_scale : mag_scale;
      end
      res.x = round_sat_q16(acc[0], s);
      res.y = round_sat_q16(acc[1], s);
      res.z = round_sat_q16(acc[2], s);
      return res;
    endfunction

    function void note_request(logic [1:0] f, logic signed [15:0] rx,
                               logic signed [15:0] ry, logic signed [15:0] rz);
      pending_cal.push_back(predict_cal(f, rx, ry, rz));
    endfunction

    function int pending();
      return pending_cal.size();
    endfunction

    function void compare_field(string name, logic [1:0] tag, longint want, longint got);
      if (want != got) begin
        $display("%0t: tag %0d %s mismatch, expected %0d actual %0d",
                 $time, tag, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] tag, logic signed [31:0] x,
                               logic signed [31:0] y, logic signed [31:0] z);
      cal_result_t want;
      if (pending_cal.size() == 0) begin
        $display("%0t: result with no pending request, tag %0d x %0d y %0d z %0d",
                 $time, tag, x, y, z);
        errors++;
        return;
      end
      want = pending_cal.pop_front();
      compare_field("sensor_tag", want.tag, want.tag, tag);
      compare_field("cal_x", want.tag, want.x, x);
      compare_field("cal_y", want.tag, want.y, y);
      compare_field("cal_z", want.tag, want.z, z);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_func = imuc_pkg::FUNC_ACCEL;
  logic signed [15:0] in_raw_x = '0;
  logic signed [15:0] in_raw_y = '0;
  logic signed [15:0] in_raw_z = '0;
  logic               out_valid;
  logic [1:0]         out_sensor_tag;
  logic signed [31:0] out_cal_x;
  logic signed [31:0] out_cal_y;
  logic signed [31:0] out_cal_z;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = imuc_pkg::REG_ACCEL_SCALE;
  logic [31:0]        cfg_wdata = '0;

  cal_scoreboard sb = new();
  int            idle_cycles = 0;
  bit            no_idle = 1'b0;

  imu_axis_calibration_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_raw_x       (in_raw_x),
    .in_raw_y       (in_raw_y),
    .in_raw_z       (in_raw_z),
    .out_valid      (out_valid),
    .out_sensor_tag (out_sensor_tag),
    .out_cal_x      (out_cal_x),
    .out_cal_y      (out_cal_y),
    .out_cal_z      (out_cal_z),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_scale(cfg_index, cfg_wdata);
      if (start && !busy) sb.note_request(in_func, in_raw_x, in_raw_y, in_raw_z);
      if (out_valid) sb.check_result(out_sensor_tag, out_cal_x, out_cal_y, out_cal_z);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
      $display("FAIL");
      $finish;
    end
  end

  // start stays high across back-to-back requests
  task automatic drive_request(input logic [1:0] f, input logic signed [15:0] x,
                               input logic signed [15:0] y, input logic signed [15:0] z,
                               input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_func  <= f;
    in_raw_x <= x;
    in_raw_y <= y;
    in_raw_z <= z;
    do @(posedge clk); while (busy);
  endtask

  // sampled on the falling edge so the scoreboard has settled
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  task automatic write_scale(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_scales(input logic [31:0] a, input logic [31:0] m,
                                input logic [31:0] g, input logic [31:0] junk);
    write_scale(imuc_pkg::REG_ACCEL_SCALE, a);
    write_scale(imuc_pkg::REG_MAG_SCALE, m);
    write_scale(imuc_pkg::REG_GYRO_SCALE, g);
    write_scale(REG_UNUSED, junk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return SCALE_MAX;
      2: return $urandom();
      default: return $urandom_range(0, 1 << 23);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_raw();
    int v;
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: begin
        v = $urandom_range(0, 255);
        return 16'(v - 128);
      end
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [1:0] pick_func();
    if ($urandom_range(0, 9) == 0) return imuc_pkg::FUNC_NONE;
    return 2'($urandom_range(0, 2));
  endfunction

  initial begin
    logic [31:0] a;
    logic [31:0] m;
    logic [31:0] g;
    int          gap;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset scales: full-scale and zero samples per sensor, mixed ones for the accel
    drive_request(imuc_pkg::FUNC_ACCEL, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                  $urandom_range(0, GAP_MAX));
    drive_request(imuc_pkg::FUNC_ACCEL, 16'sh8000, 16'sh8000, 16'sh8000,
                  $urandom_range(0, GAP_MAX));
    drive_request(imuc_pkg::FUNC_ACCEL, 16'sd0, 16'sd0, 16'sd0, $urandom_range(0, GAP_MAX));
    drive_request(imuc_pkg::FUNC_ACCEL, 16'sh7FFF, 16'sh8000, 16'sd0, 0);
    drive_request(imuc_pkg::FUNC_MAG, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
    drive_request(imuc_pkg::FUNC_MAG, 16'sh8000, 16'sh8000, 16'sh8000,
                  $urandom_range(0, GAP_MAX));
    drive_request(imuc_pkg::FUNC_MAG, 16'sd0, 16'sd0, 16'sd0, 0);
    drive_request(imuc_pkg::FUNC_GYRO, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                  $urandom_range(0, GAP_MAX));
    drive_request(imuc_pkg::FUNC_GYRO, 16'sh8000, 16'sh8000, 16'sh8000, 0);
    // gyro sample equal to its offsets gives zero
    drive_request(imuc_pkg::FUNC_GYRO, 16'sd65, -16'sd13, 16'sd21, 0);
    drive_request(imuc_pkg::FUNC_GYRO, 16'sd0, 16'sd0, 16'sd0, $urandom_range(0, GAP_MAX));
    // unused select returns zeros with its tag echoed
    drive_request(imuc_pkg::FUNC_NONE, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 0);
    drive_request(imuc_pkg::FUNC_NONE, 16'sh8000, 16'sh7FFF, 16'sh8000,
                  $urandom_range(0, GAP_MAX));

    // largest scales drive both saturation limits
    wait_drained();
    program_scales(SCALE_MAX, SCALE_MAX, SCALE_MAX, '0);
    drive_request(imuc_pkg::FUNC_ACCEL, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
    drive_request(imuc_pkg::FUNC_ACCEL, 16'sh8000, 16'sh8000, 16'sh8000, 0);
    drive_request(imuc_pkg::FUNC_MAG, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                  $urandom_range(0, GAP_MAX));
    drive_request(imuc_pkg::FUNC_MAG, 16'sh8000, 16'sh7FFF, 16'sh8000, 0);
    drive_request(imuc_pkg::FUNC_GYRO, 16'sh7FFF, 16'sh8000, 16'sd65, 0);
    drive_request(imuc_pkg::FUNC_GYRO, 16'sh8000, 16'sh7FFF, 16'sd21,
                  $urandom_range(0, GAP_MAX));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      if (p == 0) begin
        a = '0;
        m = '0;
        g = '0;
      end else if (p == 1) begin
        a = ACCEL_SCALE_RESET + $urandom_range(0, 4095);
        m = MAG_SCALE_RESET + $urandom_range(0, 4095);
        g = GYRO_SCALE_RESET + $urandom_range(0, 4095);
      end else begin
        a = pick_scale();
        m = pick_scale();
        g = pick_scale();
      end
      program_scales(a, m, g, $urandom());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 31) == 0) no_idle = !no_idle;
        gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
        drive_request(pick_func(), pick_raw(), pick_raw(), pick_raw(), gap);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
